// ===== rtl/mpw_pkg.sv =====
// Shared types and constants for the molecule periodic wrap block.
package mpw_pkg;

    // Coordinate and cell length widths (Q16.16)
    localparam int COORD_WIDTH     = 32;
    localparam int CELL_WIDTH      = 31;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CELL_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CELL_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CELL_Z = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [CELL_WIDTH-1:0]         t_cell;

    // Input beat: one atom
    typedef struct packed {
        t_coord coord_x;
        t_coord coord_y;
        t_coord coord_z;
        logic   starts_molecule;
    } t_in_beat;

    // Output beat: one wrapped atom
    typedef struct packed {
        t_coord wrapped_x;
        t_coord wrapped_y;
        t_coord wrapped_z;
        logic   saturated;
    } t_out_beat;

endpackage

// ===== rtl/molecule_periodic_wrap.sv =====
// Channel  | Direction | Handshake           | Beat
// ---------+-----------+---------------------+---------------------------------
// in       | input     | i_in_valid/o_in_stall  | t_in_beat: coords + first flag
// out      | output    | o_out_valid/i_out_stall| t_out_beat: wrapped coords + sat
// cfg      | input     | i_cfg_valid/o_cfg_ready| index + 31-bit cell length
//
// Each axis goes through one shared datapath under a small sequencer, axis by axis.
// An atom that does not start a molecule takes one add per axis and then a load
// of the output register. A first atom adds, per axis, a setup state and, if that
// axis wraps, COORD_WIDTH remainder steps and the MAG1 and MAG2 states that form
// the shift. o_in_stall is high while an atom is in work; the output register
// lets the next atom enter while a beat waits.
// Reset is synchronous, active low, and clears the cell lengths and shifts.
module molecule_periodic_wrap (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  mpw_pkg::t_in_beat                        i_in,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output mpw_pkg::t_out_beat                       o_out,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [mpw_pkg::CFG_INDEX_WIDTH-1:0]      i_cfg_index,
    input  mpw_pkg::t_cell                           i_cfg_data
);

    localparam int W     = mpw_pkg::COORD_WIDTH;
    localparam int CW    = mpw_pkg::CELL_WIDTH;
    localparam int AW    = ((W > CW) ? W : CW) + 2;
    localparam int RW    = CW + 1;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MAG1  = 3'd3;
    localparam logic [2:0] S_MAG2  = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

    // Control state
    logic [2:0]            r_state;
    logic [1:0]            r_axis;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    mpw_pkg::t_cell        r_cell  [0:2];
    logic signed [W:0]     r_shift [0:2];

    // Working payload
    mpw_pkg::t_coord       r_coord [0:2];
    mpw_pkg::t_coord       r_res   [0:2];
    logic                  r_start;
    logic                  r_neg;
    logic                  r_sat;
    logic [W-1:0]          r_num;
    logic [RW-1:0]         r_rem;
    mpw_pkg::t_out_beat    r_out;

    // Operands of the current axis
    mpw_pkg::t_coord       w_c;
    mpw_pkg::t_cell        w_len;
    logic signed [AW-1:0]  w_c2;
    logic [AW-1:0]         w_abs2;
    logic [AW-1:0]         w_len_ext;
    logic [AW-1:0]         w_excess;
    logic                  w_wrap;
    logic [RW:0]           w_rr;
    logic [RW+1:0]         w_div;
    logic [RW-1:0]         w_rem_next;
    logic [AW-1:0]         w_quot2;
    logic [AW-1:0]         w_mag;
    logic [AW-1:0]         w_shift;
    logic signed [W+1:0]   w_sum;
    mpw_pkg::t_coord       w_sat_val;
    logic                  w_ovf;
    logic                  w_out_load;

    assign w_c       = r_coord[r_axis];
    assign w_len     = r_cell[r_axis];
    assign w_len_ext = {{(AW-CW){1'b0}}, w_len};

    // Setup: |2c| - L - 1 is nonnegative exactly when the atom lies outside the box
    always_comb begin
        w_c2     = {{(AW-W-1){w_c[W-1]}}, w_c, 1'b0};
        w_abs2   = w_c[W-1] ? (AW'(0) - w_c2) : w_c2;
        w_excess = w_abs2 - w_len_ext - AW'(1);
        w_wrap   = !w_excess[AW-1] && (w_len != '0);
    end

    // One restoring step of the remainder by 2L
    always_comb begin
        w_rr       = {r_rem, r_num[r_cnt]};
        w_div      = {1'b0, w_rr} - {2'b00, w_len, 1'b0};
        w_rem_next = w_div[RW+1] ? w_rr[RW-1:0] : w_div[RW-1:0];
    end

    // Shift magnitude: (N - rem) / 2 + L
    always_comb begin
        w_quot2 = {{(AW-W){1'b0}}, r_num} - {{(AW-RW){1'b0}}, r_rem};
        w_mag   = {{(AW-W+1){1'b0}}, r_num[W-1:1]} + w_len_ext;
        w_shift = r_neg ? (AW'(0) - w_mag) : w_mag;
    end

    // Apply the stored shift with saturation
    always_comb begin
        w_sum = {{2{w_c[W-1]}}, w_c} + {r_shift[r_axis][W], r_shift[r_axis]};
        w_ovf = (w_sum[W+1] != w_sum[W-1]) || (w_sum[W] != w_sum[W-1]);
        if (!w_ovf) begin
            w_sat_val = w_sum[W-1:0];
        end else if (w_sum[W+1]) begin
            w_sat_val = COORD_MIN;
        end else begin
            w_sat_val = COORD_MAX;
        end
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Sequencer, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cell[i]  <= '0;
                r_shift[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mpw_pkg::CFG_CELL_X: r_cell[0] <= i_cfg_data;
                    mpw_pkg::CFG_CELL_Y: r_cell[1] <= i_cfg_data;
                    mpw_pkg::CFG_CELL_Z: r_cell[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_axis  <= AXIS_X;
                        r_state <= i_in.starts_molecule ? S_SETUP : S_APPLY;
                    end
                end
                S_SETUP: begin
                    r_cnt <= CNT_LAST;
                    if (w_wrap) begin
                        r_state <= S_DIV;
                    end else begin
                        r_shift[r_axis] <= '0;
                        r_state         <= S_APPLY;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_MAG1;
                    end
                end
                S_MAG1: begin
                    r_state <= S_MAG2;
                end
                S_MAG2: begin
                    r_shift[r_axis] <= w_shift[W:0];
                    r_state         <= S_APPLY;
                end
                S_APPLY: begin
                    if (r_axis == AXIS_Z) begin
                        r_state <= S_OUT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= r_start ? S_SETUP : S_APPLY;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_coord[0] <= i_in.coord_x;
                    r_coord[1] <= i_in.coord_y;
                    r_coord[2] <= i_in.coord_z;
                    r_start    <= i_in.starts_molecule;
                    r_sat      <= 1'b0;
                end
            end
            S_SETUP: begin
                r_num <= w_excess[W-1:0];
                r_rem <= '0;
                r_neg <= !w_c[W-1];
            end
            S_DIV: begin
                r_rem <= w_rem_next;
            end
            S_MAG1: begin
                r_num <= w_quot2[W-1:0];
            end
            S_APPLY: begin
                r_res[r_axis] <= w_sat_val;
                r_sat         <= r_sat | w_ovf;
            end
            default: ;
        endcase

        if (w_out_load) begin
            r_out.wrapped_x <= r_res[0];
            r_out.wrapped_y <= r_res[1];
            r_out.wrapped_z <= r_res[2];
            r_out.saturated <= r_sat;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/mpw_check.sv =====
// Port-level checks for the molecule periodic wrap block.
module mpw_check (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    input  logic                                     o_in_stall,
    input  logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    input  mpw_pkg::t_out_beat                       o_out
);

    // A waiting output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // An accepted atom keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting an atom");

    // A new output beat is only produced while an atom is in work
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output beat appeared with no atom in work");

    // No result in the cycle right after an atom is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("output beat appeared too early");

endmodule

bind molecule_periodic_wrap mpw_check u_mpw_check (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

import mpw_pkg::*;

localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
localparam longint COORD_MIN = -COORD_MAX - 1;

// Tracks the per-molecule shift and the queue of wrapped atoms still owed by the block
class wrap_scoreboard;
    longint    cell_len[3];
    longint    mol_shift[3];
    t_out_beat wrapped_q[$];
    int        errors;
    int        atoms;
    int        mol_starts;
    int        sat_count;

    function new();
        for (int i = 0; i < 3; i++) begin
            cell_len[i]  = 0;
            mol_shift[i] = 0;
        end
        errors     = 0;
        atoms      = 0;
        mol_starts = 0;
        sat_count  = 0;
    endfunction

    function void set_cell(logic [CFG_INDEX_WIDTH-1:0] idx, t_cell len);
        case (idx)
            CFG_CELL_X: cell_len[0] = longint'(len);
            CFG_CELL_Y: cell_len[1] = longint'(len);
            CFG_CELL_Z: cell_len[2] = longint'(len);
            default: ;
        endcase
    endfunction

    // Whole cell lengths that bring c into [-len/2, len/2]; 2c vs len keeps it exact
    function longint image_shift(longint c, longint len);
        longint two_c;
        longint d;
        longint n;
        if (len == 0)
            return 0;
        two_c = 2 * c;
        if (two_c > len) begin
            d = two_c - len;
            n = (d + 2 * len - 1) / (2 * len);
            return -(n * len);
        end
        if (two_c < -len) begin
            d = -two_c - len;
            n = (d + 2 * len - 1) / (2 * len);
            return n * len;
        end
        return 0;
    endfunction

    function t_coord add_shift(longint c, longint s, inout bit sat);
        longint r;
        r = c + s;
        if (r > COORD_MAX) begin
            r   = COORD_MAX;
            sat = 1'b1;
        end else if (r < COORD_MIN) begin
            r   = COORD_MIN;
            sat = 1'b1;
        end
        return t_coord'(r);
    endfunction

    function void note_atom(t_in_beat b);
        longint    c[3];
        bit        sat;
        t_out_beat w;
        c[0] = longint'(b.coord_x);
        c[1] = longint'(b.coord_y);
        c[2] = longint'(b.coord_z);
        if (b.starts_molecule) begin
            for (int i = 0; i < 3; i++)
                mol_shift[i] = image_shift(c[i], cell_len[i]);
            mol_starts++;
        end
        sat = 1'b0;
        w.wrapped_x = add_shift(c[0], mol_shift[0], sat);
        w.wrapped_y = add_shift(c[1], mol_shift[1], sat);
        w.wrapped_z = add_shift(c[2], mol_shift[2], sat);
        w.saturated = sat;
        if (sat)
            sat_count++;
        wrapped_q.push_back(w);
        atoms++;
    endfunction

    function void check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    function void check_wrapped(t_out_beat got);
        t_out_beat exp_b;
        if (wrapped_q.size() == 0) begin
            $error("output beat with no atom pending: x %0d y %0d z %0d sat %0b",
                   got.wrapped_x, got.wrapped_y, got.wrapped_z, got.saturated);
            errors++;
            return;
        end
        exp_b = wrapped_q.pop_front();
        check_field("wrapped_x", longint'(exp_b.wrapped_x), longint'(got.wrapped_x));
        check_field("wrapped_y", longint'(exp_b.wrapped_y), longint'(got.wrapped_y));
        check_field("wrapped_z", longint'(exp_b.wrapped_z), longint'(got.wrapped_z));
        check_field("saturated", longint'(exp_b.saturated), longint'(got.saturated));
    endfunction

    function int outstanding();
        return wrapped_q.size();
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_ATOMS  = 236;
    localparam int NUM_PHASES   = 8;
    localparam longint ANGSTROM = 64'sd65536;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_beat           i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_beat          o_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    t_cell              i_cfg_data;

    wrap_scoreboard sb = new();

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_req;
    int cycles;
    int settings_used;

    molecule_periodic_wrap DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL molecule_periodic_wrap");
        $finish;
    end

    // Output side: check accepted beats, then pick next cycle's stall
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_wrapped(o_out);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    function automatic void set_idling(int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
            default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
        endcase
    endfunction

    function automatic int idle_gap();
        int n;
        n = 0;
        while (tx_idle_pct != 0 && n < 40 && $urandom_range(0, 99) < tx_idle_pct)
            n++;
        return n;
    endfunction

    function automatic t_coord clamp_coord(longint v);
        if (v > COORD_MAX)
            return t_coord'(COORD_MAX);
        if (v < COORD_MIN)
            return t_coord'(COORD_MIN);
        return t_coord'(v);
    endfunction

    function automatic t_in_beat mk_atom(longint x, longint y, longint z, bit first);
        t_in_beat b;
        b.coord_x         = t_coord'(x);
        b.coord_y         = t_coord'(y);
        b.coord_z         = t_coord'(z);
        b.starts_molecule = first;
        return b;
    endfunction

    // Coordinate for an axis of cell length len: edges, raw noise, or a few cells out
    function automatic t_coord gen_coord(longint len);
        int     pick;
        longint k;
        longint c;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            case ($urandom_range(0, 7))
                0: c = COORD_MAX;
                1: c = COORD_MIN;
                2: c = 0;
                3: c = -1;
                4: c = len / 2;
                5: c = -(len / 2);
                6: c = len / 2 + 1;
                default: c = -(len / 2) - 1;
            endcase
            return clamp_coord(c);
        end
        if (pick < 37)
            return t_coord'($urandom);
        if (len == 0)
            return clamp_coord(longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216);
        k = longint'($urandom_range(0, 6));
        if ($urandom_range(0, 1))
            k = -k;
        c = k * len + (longint'($urandom) % (2 * len + 1)) - len;
        return clamp_coord(c);
    endfunction

    // Offer one atom; the beat is taken at the first edge without stall
    task automatic send_atom(t_in_beat b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_atom(b);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // Only called with the block idle
    task automatic set_cells(t_cell cx, t_cell cy, t_cell cz);
        logic [CFG_INDEX_WIDTH-1:0] idx[3];
        t_cell                      val[3];
        idx = '{CFG_CELL_X, CFG_CELL_Y, CFG_CELL_Z};
        val = '{cx, cy, cz};
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_cell(idx[i], val[i]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One molecule: a first atom, then neighbors close to it or anywhere
    task automatic send_molecule(int n_atoms);
        t_in_beat first_b;
        t_in_beat b;
        first_b = mk_atom(gen_coord(sb.cell_len[0]), gen_coord(sb.cell_len[1]),
                          gen_coord(sb.cell_len[2]), 1'b1);
        send_atom(first_b);
        for (int i = 1; i < n_atoms; i++) begin
            if ($urandom_range(0, 99) < 80) begin
                b = mk_atom(
                    longint'(first_b.coord_x) + longint'($urandom_range(0, 131072)) - 65536,
                    longint'(first_b.coord_y) + longint'($urandom_range(0, 131072)) - 65536,
                    longint'(first_b.coord_z) + longint'($urandom_range(0, 131072)) - 65536,
                    1'b0);
            end else begin
                b = mk_atom(gen_coord(sb.cell_len[0]), gen_coord(sb.cell_len[1]),
                            gen_coord(sb.cell_len[2]), 1'b0);
            end
            send_atom(b);
        end
    endtask

    task automatic run_phase(int phase);
        int  sent;
        int  n;
        bit  held;
        bit  paused;
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        set_idling(phase % 4);
        while (sent < PHASE_ATOMS) begin
            // long output hold-off while atoms keep coming, then a full drain
            if ((phase == 0 || phase == 5) && !held && sent > PHASE_ATOMS / 3) begin
                rx_hold_req = 300 + $urandom_range(0, 200);
                held        = 1'b1;
            end
            if ((phase == 0 || phase == 5) && !paused && sent > 2 * PHASE_ATOMS / 3) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 8) begin
                // stray atom with no first flag: keeps the previous shift
                send_atom(mk_atom(gen_coord(sb.cell_len[0]), gen_coord(sb.cell_len[1]),
                                  gen_coord(sb.cell_len[2]), 1'b0));
                sent++;
            end else begin
                n = $urandom_range(1, 7);
                send_molecule(n);
                sent += n;
            end
        end
    endtask

    initial begin
        t_cell cx;
        t_cell cy;
        t_cell cz;
        int    directed_atoms;

        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        rx_hold_req   = 0;
        settings_used = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in          <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_CELL_X;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: atoms before any first atom use the zero reset shift
        send_atom(mk_atom(COORD_MAX, COORD_MIN, 0, 1'b0));
        send_atom(mk_atom(COORD_MIN, COORD_MAX, -1, 1'b0));
        // all cells zero: no wrap at all
        send_atom(mk_atom(64'sh1234_5678, COORD_MIN, COORD_MAX, 1'b1));
        wait_drained();

        set_cells(t_cell'(10 * ANGSTROM), t_cell'(1), t_cell'(COORD_MAX));
        // exact half cell stays, overflowing neighbors saturate
        send_atom(mk_atom(5 * ANGSTROM, 0, COORD_MAX, 1'b1));
        send_atom(mk_atom(-5 * ANGSTROM, COORD_MAX, COORD_MIN, 1'b0));
        send_atom(mk_atom(-5 * ANGSTROM, COORD_MIN, COORD_MIN, 1'b1));
        send_atom(mk_atom(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        // just past half cell on both sides
        send_atom(mk_atom(5 * ANGSTROM + 1, 1, 0, 1'b1));
        send_atom(mk_atom(-5 * ANGSTROM - 1, -1, -1, 1'b1));
        send_atom(mk_atom(64'sh7FFF_0000, 64'sh4000_0000, 64'sh3FFF_FFFF, 1'b1));
        send_atom(mk_atom(COORD_MIN, 0, 64'sh1234_5678, 1'b0));
        wait_drained();

        // cell change mid-molecule: stored shift holds until the next first atom
        set_cells(t_cell'(20 * ANGSTROM), t_cell'(0), t_cell'(2));
        send_atom(mk_atom(ANGSTROM, COORD_MAX, COORD_MIN, 1'b0));
        send_atom(mk_atom(30 * ANGSTROM, COORD_MIN, COORD_MAX, 1'b1));
        send_atom(mk_atom(-30 * ANGSTROM, COORD_MAX, -3, 1'b0));
        wait_drained();

        set_cells(t_cell'(COORD_MAX), t_cell'(COORD_MAX), t_cell'(COORD_MAX));
        send_atom(mk_atom(COORD_MIN, COORD_MAX, 64'sh3FFF_FFFF, 1'b1));
        send_atom(mk_atom(COORD_MAX, COORD_MIN, 0, 1'b0));
        send_atom(mk_atom(-64'sh4000_0000, 64'sh4000_0000, 64'sh4000_0000, 1'b1));
        wait_drained();
        directed_atoms = sb.atoms;

        // Random phases over typical, tiny, huge, disabled and random cells
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    cx = t_cell'(10 * ANGSTROM);
                    cy = t_cell'(12 * ANGSTROM);
                    cz = t_cell'(8 * ANGSTROM);
                end
                1: begin cx = t_cell'(1); cy = t_cell'(2); cz = t_cell'(3); end
                2: begin
                    cx = t_cell'(COORD_MAX);
                    cy = t_cell'(COORD_MAX);
                    cz = t_cell'(COORD_MAX);
                end
                3: begin cx = t_cell'(0); cy = t_cell'(20 * ANGSTROM); cz = t_cell'(0); end
                4: begin
                    cx = t_cell'($urandom_range(1, 32'h7FFF_FFFF));
                    cy = t_cell'($urandom_range(1, 32'h7FFF_FFFF));
                    cz = t_cell'($urandom_range(1, 32'h7FFF_FFFF));
                end
                5: begin
                    cx = t_cell'($urandom_range(1, 32'h0000_FFFF));
                    cy = t_cell'($urandom_range(1, 32'h0000_FFFF));
                    cz = t_cell'($urandom_range(1, 32'h0000_FFFF));
                end
                6: begin
                    cx = t_cell'(64'h4000_0000);
                    cy = t_cell'(64'h7FFF_FFFE);
                    cz = t_cell'(1);
                end
                default: begin
                    cx = t_cell'($urandom);
                    cy = t_cell'($urandom);
                    cz = t_cell'($urandom);
                end
            endcase
            set_cells(cx, cy, cz);
            run_phase(p);
            wait_drained();
        end

        // trailing window: any late or extra beat is flagged by the output side
        repeat (150) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $error("%0d wrapped atoms never came out", sb.outstanding());
            sb.errors++;
        end

        $display("Covered %0d atoms (%0d directed), %0d molecule starts, %0d saturated,",
                 sb.atoms, directed_atoms, sb.mol_starts, sb.sat_count);
        $display("across %0d cell settings with mixed input gaps and output stalls",
                 settings_used);
        if (sb.errors == 0) begin
            $display("PASS molecule_periodic_wrap");
        end else begin
            $display("FAIL molecule_periodic_wrap");
        end
        $finish;
    end

endmodule
